FILE: sv/htd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants of the Huffman tree-table decoder
// Field widths, command and register codes, the queued command record and
// the walker state encoding.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int ADDR_W     = 14;  // load address
  localparam int NODE_W     = 14;  // node table entry / tree position
  localparam int NODE_SUM_W = 15;  // tree position plus one coded bit
  localparam int VALUE_W    = 16;  // symbol value / running sum
  localparam int COUNT_W    = 13;  // symbol_count register
  localparam int BITS_W     = 7;   // valid_bits field
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [COUNT_W-1:0] SYMBOL_COUNT_RST = 13'd256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MODE   = 1'b1;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_LOAD_NODE   = 2'd0,
    CMD_LOAD_SYMBOL = 2'd1,
    CMD_DECODE      = 2'd2
  } htd_cmd_code_t;

  // Command record passed from the front end to the walker
  typedef struct packed {
    htd_cmd_code_t        op;
    logic [ADDR_W-1:0]    address;
    logic [VALUE_W-1:0]   load_value;
    logic [BITS_W-1:0]    walk_bits;   // already limited to the word width
    logic                 first;
  } htd_cmd_t;

  // Configuration seen by the walker
  typedef struct packed {
    logic [COUNT_W-1:0] symbol_count;
    logic               delta_mode;
  } htd_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_NODE,
    ST_SYM,
    ST_FLUSH
  } htd_state_t;

endpackage

`default_nettype wire

FILE: sv/htd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htd_front: command intake
// Accepts input transfers, drops unused command codes, limits the bit count
// to the word width and hands the command record to the queue.
// ----------------------------------------------------------------------------
module htd_front
  import htd_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_command,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic [VALUE_W-1:0]    in_load_value,
  input  wire logic [WORD_BITS-1:0]  in_code_word,
  input  wire logic [BITS_W-1:0]     in_valid_bits,
  input  wire logic                  in_first_word,
  output logic                       q_push,
  output htd_cmd_t                   q_cmd,
  output logic [WORD_BITS-1:0]       q_word,
  input  wire logic                  q_full
);

  logic keep;

  always_comb begin
    case (in_command)
      CMD_LOAD_NODE, CMD_LOAD_SYMBOL, CMD_DECODE: keep = 1'b1;
      default: keep = 1'b0;  // unused code: take it and drop it
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && keep;

  always_comb begin
    q_cmd.op         = htd_cmd_code_t'(in_command);
    q_cmd.address    = in_address;
    q_cmd.load_value = in_load_value;
    q_cmd.first      = in_first_word;
    if (32'(in_valid_bits) > WORD_BITS) begin
      q_cmd.walk_bits = BITS_W'(WORD_BITS);
    end else begin
      q_cmd.walk_bits = in_valid_bits;
    end
  end

  assign q_word = in_code_word;

endmodule

`default_nettype wire

FILE: sv/htd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htd_queue: two-entry command queue
// Decouples command intake from the tree walker.
// ----------------------------------------------------------------------------
module htd_queue #(
  parameter int W = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  push_data,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop,
  output logic [W-1:0]       pop_data
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/htd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htd_back: table loader and tree walker
// Holds the node table and symbol store, carries out load commands and walks
// the tree one coded bit per cycle, save at leaves and output stalls. Keeps
// one symbol pending to flag a word's last, and drives the output register.
// ----------------------------------------------------------------------------
module htd_back
  import htd_pkg::*;
#(
  parameter int TABLE_DEPTH = 16384,
  parameter int MAX_SYMBOLS = 4096,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire htd_cfg_t              cfg,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire htd_cmd_t              q_cmd,
  input  wire logic [WORD_BITS-1:0]  q_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_W-1:0]         out_symbol,
  output logic                       out_last_of_word
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SAW = $clog2(MAX_SYMBOLS);

  // Memories
  logic [NODE_W-1:0]  node_mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] sym_mem  [MAX_SYMBOLS];
  logic [NODE_W-1:0]  node_rdata_r;
  logic               node_oob_r;
  logic [VALUE_W-1:0] sym_rdata_r;
  logic               sym_oob_r;

  logic               node_we, node_re, node_oob_nxt;
  logic [AW-1:0]      node_waddr, node_raddr;
  logic               sym_we, sym_re, sym_oob_nxt;
  logic [SAW-1:0]     sym_waddr, sym_raddr;

  // Walker state
  htd_state_t           state_r, state_nxt;
  logic [NODE_W-1:0]    pos_r, pos_nxt;
  logic [VALUE_W-1:0]   sum_r, sum_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [BITS_W-1:0]    bits_left_r, bits_left_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [VALUE_W-1:0]   pend_sym_r, pend_sym_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   out_symbol_r;
  logic                 out_last_r;

  logic                 out_push, out_push_last;
  logic [VALUE_W-1:0]   out_push_sym;
  logic                 out_space, commit, pop;
  logic [NODE_W-1:0]    sc_ext, pos_start, node_val, node_base;
  logic [NODE_SUM_W-1:0] node_sum;
  logic                 is_leaf;
  logic [VALUE_W-1:0]   sym_val, sum_add, emit_val;

  assign sc_ext    = NODE_W'(cfg.symbol_count);
  assign pos_start = (pos_r < sc_ext) ? sc_ext : pos_r;
  assign node_val  = node_oob_r ? '0 : node_rdata_r;
  assign is_leaf   = (node_val < sc_ext);
  assign sym_val   = sym_oob_r ? '0 : sym_rdata_r;
  assign sum_add   = sum_r + sym_val;
  assign emit_val  = cfg.delta_mode ? sum_add : sym_val;
  assign out_space = !out_valid_r || out_ready;
  assign commit    = !pend_valid_r || out_space;
  assign q_ready   = (state_r == ST_IDLE);
  assign pop       = q_valid && q_ready;

  always_comb begin
    case (state_r)
      ST_ADDR: node_base = pos_start;
      ST_NODE: node_base = node_val;
      default: node_base = sc_ext;
    endcase
  end

  assign node_sum     = NODE_SUM_W'(node_base) + NODE_SUM_W'(word_r[0]);
  assign node_raddr   = AW'(node_sum);
  assign node_oob_nxt = (32'(node_sum) >= TABLE_DEPTH);
  assign sym_raddr    = SAW'(node_val);
  assign sym_oob_nxt  = (32'(node_val) >= MAX_SYMBOLS);
  assign node_waddr   = AW'(q_cmd.address);
  assign sym_waddr    = SAW'(q_cmd.address);

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    word_nxt       = word_r;
    bits_left_nxt  = bits_left_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    node_we        = 1'b0;
    node_re        = 1'b0;
    sym_we         = 1'b0;
    sym_re         = 1'b0;
    out_push       = 1'b0;
    out_push_sym   = pend_sym_r;
    out_push_last  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.op)
            CMD_LOAD_NODE: begin
              node_we = (32'(q_cmd.address) < TABLE_DEPTH);
            end
            CMD_LOAD_SYMBOL: begin
              sym_we = (32'(q_cmd.address) < MAX_SYMBOLS);
            end
            CMD_DECODE: begin
              if (q_cmd.first) begin
                pos_nxt = sc_ext;
                sum_nxt = '0;
              end
              word_nxt      = q_word;
              bits_left_nxt = q_cmd.walk_bits;
              if (q_cmd.walk_bits != '0) begin
                state_nxt = ST_ADDR;
              end
            end
            default: ;
          endcase
        end
      end

      ST_ADDR: begin
        // first bit of a word: start at the root if parked on a leaf
        node_re       = 1'b1;
        word_nxt      = word_r >> 1;
        bits_left_nxt = bits_left_r - 1'b1;
        state_nxt     = ST_NODE;
      end

      ST_NODE: begin
        if (is_leaf) begin
          sym_re    = 1'b1;
          pos_nxt   = sc_ext;
          state_nxt = ST_SYM;
        end else begin
          pos_nxt = node_val;
          if (bits_left_r != '0) begin
            node_re       = 1'b1;
            word_nxt      = word_r >> 1;
            bits_left_nxt = bits_left_r - 1'b1;
          end else begin
            state_nxt = pend_valid_r ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_SYM: begin
        // hold here until the previous symbol can move to the output
        if (commit) begin
          out_push       = pend_valid_r;
          pend_valid_nxt = 1'b1;
          pend_sym_nxt   = emit_val;
          if (cfg.delta_mode) begin
            sum_nxt = sum_add;
          end
          if (bits_left_r != '0) begin
            node_re       = 1'b1;
            word_nxt      = word_r >> 1;
            bits_left_nxt = bits_left_r - 1'b1;
            state_nxt     = ST_NODE;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_space) begin
          out_push       = 1'b1;
          out_push_last  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      sum_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      sum_r        <= sum_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    bits_left_r <= bits_left_nxt;
    pend_sym_r  <= pend_sym_nxt;
    if (out_push) begin
      out_symbol_r <= out_push_sym;
      out_last_r   <= out_push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= q_cmd.load_value[NODE_W-1:0];
    end
    if (node_re) begin
      node_rdata_r <= node_mem[node_raddr];
      node_oob_r   <= node_oob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= q_cmd.load_value;
    end
    if (sym_re) begin
      sym_rdata_r <= sym_mem[sym_raddr];
      sym_oob_r   <= sym_oob_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_last_of_word = out_last_r;

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("symbol still pending with walker idle");

  a_sym_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SYM && !commit) |=> $stable(sym_rdata_r) && $stable(sum_r))
    else $error("symbol data or sum changed during output stall");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> 32'(bits_left_r) <= WORD_BITS)
    else $error("bit counter beyond word width");

  a_leaf_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NODE && is_leaf) |=> pos_r == sc_ext && state_r == ST_SYM)
    else $error("leaf did not return the walk to the root");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_space) |=> out_valid_r && out_last_r)
    else $error("final symbol of a word not flagged");
`endif

endmodule

`default_nettype wire

FILE: sv/huffman_tree_table_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder: Huffman decoder walking a loaded tree table
// Usage: load node entries (command 0) and symbol values (command 1) on the
// input channel, then send data words (command 2). Coded bits are taken LSB
// first; each bit steps one node of the tree. Every leaf reached yields one
// output transfer carrying the symbol value, or the 16-bit running sum in
// delta mode; the last symbol of a word has last_of_word set. Command 3 is
// taken and dropped.
// A load is written without the walker leaving idle. A data word of N > 0
// bits is walked with one dependent node-table read per bit and one
// symbol-store read per leaf; when the word yields any symbols, a flush
// step then flags the final symbol and moves it out.
// Up to two commands queue ahead of the walker, so the input keeps taking
// transfers while a word is walked.
// Configuration (symbol_count, delta_mode) is to be written through cfg_we
// while the block is idle; it does not enforce this. Reset empties the
// queue and output register, zeroes the walk position and running sum, sets
// symbol_count to 256, delta mode off; tables are kept, undefined until loaded.
// When the receiver stalls, the walker holds at the next leaf until the
// output register frees up; the queue fills and then input ready drops.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder
  import htd_pkg::*;
#(
  parameter int TABLE_DEPTH = 16384,
  parameter int MAX_SYMBOLS = 4096,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_command,
  input  wire logic [ADDR_W-1:0]      in_address,
  input  wire logic [VALUE_W-1:0]     in_load_value,
  input  wire logic [WORD_BITS-1:0]   in_code_word,
  input  wire logic [BITS_W-1:0]      in_valid_bits,
  input  wire logic                   in_first_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [VALUE_W-1:0]          out_symbol,
  output logic                        out_last_of_word
);

  localparam int QW = $bits(htd_cmd_t) + WORD_BITS;

  htd_cfg_t             cfg_r, cfg_nxt;
  logic                 q_push, q_full, q_valid, q_ready;
  htd_cmd_t             push_cmd, pop_cmd;
  logic [WORD_BITS-1:0] push_word, pop_word;
  logic [QW-1:0]        pop_data;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SYMBOL_COUNT: cfg_nxt.symbol_count = cfg_data[COUNT_W-1:0];
        CFG_DELTA_MODE:   cfg_nxt.delta_mode   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_count <= SYMBOL_COUNT_RST;
      cfg_r.delta_mode   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Intake: classify and queue commands
  htd_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_load_value (in_load_value),
    .in_code_word  (in_code_word),
    .in_valid_bits (in_valid_bits),
    .in_first_word (in_first_word),
    .q_push        (q_push),
    .q_cmd         (push_cmd),
    .q_word        (push_word),
    .q_full        (q_full)
  );

  htd_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_cmd, push_word}),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_ready),
    .pop_data  (pop_data)
  );

  assign pop_cmd  = pop_data[QW-1:WORD_BITS];
  assign pop_word = pop_data[WORD_BITS-1:0];

  // Walker: loads, tree walk and output register
  htd_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .WORD_BITS   (WORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_cmd            (pop_cmd),
    .q_word           (pop_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_last_of_word (out_last_of_word)
  );

endmodule

`default_nettype wire

FILE: sim/htd_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_decode_checker: symbol predictor and scoreboard for the tree decoder
// Watches the configuration port and both channels, walks its own copy of
// the node table for every accepted data word and compares each output
// transfer with the oldest predicted symbol.
// ----------------------------------------------------------------------------
module htd_decode_checker
  import htd_pkg::*;
#(
  parameter int TABLE_DEPTH = 16384,
  parameter int MAX_SYMBOLS = 4096,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [1:0]            in_command,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic [VALUE_W-1:0]    in_load_value,
  input  wire logic [WORD_BITS-1:0]  in_code_word,
  input  wire logic [BITS_W-1:0]     in_valid_bits,
  input  wire logic                  in_first_word,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [VALUE_W-1:0]    out_symbol,
  input  wire logic                  out_last_of_word,
  output int                         mismatch_count,
  output int                         pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] symbol;
    logic               last;
  } decoded_t;

  logic [NODE_W-1:0]  node_mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] sym_mem  [MAX_SYMBOLS];
  int                 walk_pos;
  logic [VALUE_W-1:0] sum_acc;
  logic [COUNT_W-1:0] n_symbols;
  logic               delta_on;
  decoded_t           expected_symbols [$];

  // Reads past the table end return zero.
  function automatic int node_at(input int idx);
    if (idx >= TABLE_DEPTH) begin
      return 0;
    end
    return int'(node_mem[idx]);
  endfunction

  // Leaves beyond the symbol store decode as zero.
  function automatic logic [VALUE_W-1:0] symbol_at(input int idx);
    if (idx >= MAX_SYMBOLS) begin
      return '0;
    end
    return sym_mem[idx];
  endfunction

  task automatic walk_word(input logic [WORD_BITS-1:0] word, input logic [BITS_W-1:0] nbits,
                           input logic restart);
    int                 bit_total;
    int                 pos;
    int                 nxt;
    logic [VALUE_W-1:0] value;
    decoded_t           held;
    bit                 have_held;
    have_held = 1'b0;
    held      = '0;
    if (restart) begin
      walk_pos = int'(n_symbols);
      sum_acc  = '0;
    end
    bit_total = (nbits > WORD_BITS) ? WORD_BITS : int'(nbits);
    for (int i = 0; i < bit_total; i++) begin
      pos = (walk_pos < int'(n_symbols)) ? int'(n_symbols) : walk_pos;
      nxt = node_at(pos + int'(word[i]));
      if (nxt < int'(n_symbols)) begin
        value = symbol_at(nxt);
        if (delta_on) begin
          sum_acc = sum_acc + value;
          value   = sum_acc;
        end
        // hold back one symbol so the final one can carry the last flag
        if (have_held) begin
          expected_symbols.insert(expected_symbols.size(), held);
        end
        held.symbol = value;
        held.last   = 1'b0;
        have_held   = 1'b1;
        walk_pos    = int'(n_symbols);
      end else begin
        walk_pos = nxt;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_symbols.insert(expected_symbols.size(), held);
    end
  endtask

  always @(posedge clk) begin : monitor
    decoded_t got;
    decoded_t want;
    if (!rst_n) begin
      walk_pos  = 0;
      sum_acc   = '0;
      n_symbols = SYMBOL_COUNT_RST;
      delta_on  = 1'b0;
      expected_symbols.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        got.symbol = out_symbol;
        got.last   = out_last_of_word;
        if (expected_symbols.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected output, expected none, got symbol %h last %b",
                   $time, got.symbol, got.last);
        end else begin
          want = expected_symbols.pop_front();
          if (got.symbol !== want.symbol) begin
            mismatch_count++;
            $display("%0t: symbol expected %h, got %h", $time, want.symbol, got.symbol);
          end
          if (got.last !== want.last) begin
            mismatch_count++;
            $display("%0t: last_of_word expected %b, got %b", $time, want.last, got.last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYMBOL_COUNT: n_symbols = cfg_data[COUNT_W-1:0];
          CFG_DELTA_MODE:   delta_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_LOAD_NODE: node_mem[in_address] = in_load_value[NODE_W-1:0];
          CMD_LOAD_SYMBOL: begin
            if (int'(in_address) < MAX_SYMBOLS) begin
              sym_mem[in_address] = in_load_value;
            end
          end
          CMD_DECODE: walk_word(in_code_word, in_valid_bits, in_first_word);
          default: ;
        endcase
      end
    end
    pending = expected_symbols.size();
  end

endmodule

FILE: sim/tb_huffman_tree_table_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_table_decoder: testbench of the Huffman tree-table decoder
// Loads random binary trees for a series of symbol counts and modes, then
// sends data words through them while both channels idle and stall at random.
// A checker beside the block predicts every decoded symbol; this module only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_huffman_tree_table_decoder;
  import htd_pkg::*;

  localparam int TABLE_DEPTH = 16384;
  localparam int MAX_SYMBOLS = 4096;
  localparam int WORD_BITS   = 64;

  // Command code the block takes and drops
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 16;   // random data words per phase
  localparam int DRAIN_CYCLES    = 400;  // a few words of walking with nothing to show
  localparam int HOLD_CYCLES     = 600;  // long receiver hold-off
  localparam int LIMIT_NS        = 50_000_000;

  typedef enum {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_command    = '0;
  logic [ADDR_W-1:0]     in_address    = '0;
  logic [VALUE_W-1:0]    in_load_value = '0;
  logic [WORD_BITS-1:0]  in_code_word  = '0;
  logic [BITS_W-1:0]     in_valid_bits = '0;
  logic                  in_first_word = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [VALUE_W-1:0]    out_symbol;
  logic                  out_last_of_word;
  int                    mismatch_count;
  int                    pending;

  idle_mode_t idle_mode    = IDLE_NONE;
  bit         hold_request = 1'b0;

  // Current tree: which table slots it reads and what they hold
  int                cur_count = 256;
  bit                slot_used  [TABLE_DEPTH];
  logic [NODE_W-1:0] slot_entry [TABLE_DEPTH];
  int                tree_slots [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  huffman_tree_table_decoder u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_command, .in_address, .in_load_value,
    .in_code_word, .in_valid_bits, .in_first_word,
    .out_valid, .out_ready, .out_symbol, .out_last_of_word
  );

  htd_decode_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .WORD_BITS   (WORD_BITS)
  ) u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_command, .in_address, .in_load_value,
    .in_code_word, .in_valid_bits, .in_first_word,
    .out_valid, .out_ready, .out_symbol, .out_last_of_word,
    .mismatch_count, .pending
  );

  // Receiver: stall at random per idle mode; a hold request drops ready for
  // a long stretch so the block backs up into its input.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (idle_mode)
          IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 63);
          IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 8);
          default:       out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one transfer, starting and ending at a falling edge. Valid stays
  // high on return; the next call or the drain decides what it does next.
  task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [VALUE_W-1:0] lval, input logic [WORD_BITS-1:0] word,
                           input logic [BITS_W-1:0] nbits, input logic restart);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_address    <= addr;
    in_load_value <= lval;
    in_code_word  <= word;
    in_valid_bits <= nbits;
    in_first_word <= restart;
    // sample the handshake at the rising edge
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] symbol_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Write one tree slot; the two spare entry bits carry random junk.
  task automatic load_node(input int slot, input int entry);
    slot_used[slot]  = 1'b1;
    slot_entry[slot] = NODE_W'(entry);
    tree_slots.insert(tree_slots.size(), slot);
    send_item(CMD_LOAD_NODE, ADDR_W'(slot), {2'($urandom_range(3)), NODE_W'(entry)},
              {$urandom, $urandom}, BITS_W'($urandom), 1'($urandom));
  endtask

  task automatic load_symbol(input int idx, input logic [VALUE_W-1:0] value);
    send_item(CMD_LOAD_SYMBOL, ADDR_W'(idx), value, {$urandom, $urandom},
              BITS_W'($urandom), 1'($urandom));
  endtask

  // Build and load a random full binary tree rooted at the symbol count.
  // Every table slot a walk can read is written, and so is the value of every
  // leaf within the symbol store; reads past either end return zero.
  task automatic load_tree(input int max_inner, input bit edge_node);
    int open_slots [$];
    int slot;
    int inner;
    int next_pos;
    int leaf;
    int leaf_top;
    foreach (tree_slots[i]) slot_used[tree_slots[i]] = 1'b0;
    tree_slots.delete();
    next_pos = cur_count + 2;
    leaf_top = (cur_count < MAX_SYMBOLS) ? cur_count : MAX_SYMBOLS;
    if (edge_node) begin
      // root branch 0 goes to the last table slot, whose branch 1 reads past
      // the end of the table and so lands on symbol 0
      load_node(cur_count, TABLE_DEPTH - 1);
      load_symbol(0, symbol_value());
      open_slots.insert(open_slots.size(), cur_count + 1);
      open_slots.insert(open_slots.size(), TABLE_DEPTH - 1);
      inner = 2;
    end else begin
      open_slots.insert(open_slots.size(), cur_count);
      open_slots.insert(open_slots.size(), cur_count + 1);
      inner = 1;
    end
    while (open_slots.size() > 0) begin
      slot = open_slots.pop_back();
      if (inner < max_inner && $urandom_range(1) == 1) begin
        load_node(slot, next_pos);
        open_slots.insert(open_slots.size(), next_pos);
        open_slots.insert(open_slots.size(), next_pos + 1);
        next_pos += 2;
        inner++;
      end else begin
        // above the symbol store, leaves have no value to load
        if (cur_count > MAX_SYMBOLS && $urandom_range(1) == 1) begin
          leaf = $urandom_range(cur_count - 1, MAX_SYMBOLS);
        end else begin
          leaf = $urandom_range(leaf_top - 1, 0);
        end
        if (leaf < MAX_SYMBOLS) begin
          load_symbol(leaf, symbol_value());
        end
        load_node(slot, leaf);
      end
    end
  endtask

  task automatic random_word(input logic restart);
    logic [WORD_BITS-1:0] word;
    int                   nbits;
    case ($urandom_range(7))
      0:       word = '0;
      1:       word = '1;
      default: word = {$urandom, $urandom};
    endcase
    case ($urandom_range(9))
      0:       nbits = 0;
      1:       nbits = $urandom_range(127, WORD_BITS + 1);
      2:       nbits = WORD_BITS;
      default: nbits = $urandom_range(WORD_BITS - 1, 1);
    endcase
    send_item(CMD_DECODE, ADDR_W'($urandom), VALUE_W'($urandom), word, BITS_W'(nbits),
              restart);
  endtask

  // Transfers that decode nothing: harmless table writes and the dropped code.
  task automatic stray_item();
    int addr;
    case ($urandom_range(2))
      0: begin
        if ($urandom_range(1) == 1) begin
          addr = tree_slots[$urandom_range(tree_slots.size() - 1)];
        end else begin
          addr = $urandom_range(TABLE_DEPTH - 1);
        end
        // rewrite a live slot with what it already holds; anything goes elsewhere
        send_item(CMD_LOAD_NODE, ADDR_W'(addr),
                  slot_used[addr] ? {2'($urandom_range(3)), slot_entry[addr]}
                                  : VALUE_W'($urandom),
                  {$urandom, $urandom}, BITS_W'($urandom), 1'($urandom));
      end
      1: load_symbol($urandom_range(TABLE_DEPTH - 1), symbol_value());
      default: send_item(CMD_RESERVED, ADDR_W'($urandom), VALUE_W'($urandom),
                         {$urandom, $urandom}, BITS_W'($urandom), 1'($urandom));
    endcase
  endtask

  // Drop valid, wait for every predicted symbol, then let any word that
  // yields nothing finish its walk.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both registers on back-to-back edges; the delta register gets
  // junk in its unused bits.
  task automatic set_config(input int sc, input logic delta);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYMBOL_COUNT;
    cfg_data  <= CFG_DATA_W'(sc);
    @(negedge clk);
    cfg_index <= CFG_DELTA_MODE;
    cfg_data  <= {(CFG_DATA_W - 1)'($urandom), delta};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_count = sc;
  endtask

  initial begin : stimulus
    int   sc;
    logic delta;
    int   words;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_mode = idle_mode_t'(phase % 4);
      if (phase > 0) begin
        case (phase)
          1: begin sc = 1;    delta = 1'b1; end
          2: begin sc = 4096; delta = 1'b0; end
          3: begin sc = 4100; delta = 1'b1; end  // leaves past the symbol store
          4: begin sc = 2;    delta = 1'b0; end
          5: begin sc = 4096; delta = 1'b1; end
          default: begin
            sc    = $urandom_range(4096, 1);
            delta = 1'($urandom_range(1));
          end
        endcase
        set_config(sc, delta);
      end

      if (phase == 0) begin
        // Reset settings: 256 symbols, raw values
        load_tree(6, 1'b1);
        // walk starts from position zero, below the root
        send_item(CMD_DECODE, '1, '1, {$urandom, $urandom}, 7'd64, 1'b0);
        // zero bits: nothing comes out
        send_item(CMD_DECODE, '0, '0, '1, 7'd0, 1'b0);
        // alternate branch 0 / branch 1: every pair reads past the table end
        send_item(CMD_DECODE, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b1);
        // stop halfway down, resume there, then restart mid-walk
        send_item(CMD_DECODE, '1, '0, 64'h0, 7'd1, 1'b1);
        send_item(CMD_DECODE, '0, '1, 64'h0, 7'd1, 1'b0);
        send_item(CMD_DECODE, '1, '1, 64'h1, 7'd1, 1'b1);
        // bit count beyond the word clamps to the word width
        send_item(CMD_DECODE, '0, '0, '1, 7'd127, 1'b0);
        send_item(CMD_RESERVED, '1, '1, '1, '1, 1'b1);
        // symbol writes past the store are dropped
        load_symbol(MAX_SYMBOLS, 16'h1234);
        load_symbol(TABLE_DEPTH - 1, 16'hFFFF);
        load_symbol(0, 16'hFFFF);
        send_item(CMD_DECODE, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b0);
      end else if (phase == 1) begin
        // One symbol at max value: every bit is a leaf, so the running sum
        // wraps on every symbol after the first of 64.
        load_tree(1, 1'b0);
        load_symbol(0, 16'hFFFF);
        send_item(CMD_DECODE, '0, '0, '1, 7'd64, 1'b1);
      end else begin
        load_tree($urandom_range(24, 1), 1'b0);
      end

      // Random part: first word of the phase restarts the walk, since the
      // old position may point into a tree that no longer exists.
      words = 0;
      while (words < WORDS_PER_PHASE) begin
        if (words > 0 && $urandom_range(4) == 0) begin
          stray_item();
        end else begin
          random_word(words == 0 || $urandom_range(9) == 0);
          words++;
          // hold off the receiver while words keep coming
          if (idle_mode == IDLE_NONE && phase > 0 && words == 8) begin
            hold_request = 1'b1;
          end
        end
      end
    end

    idle_mode = IDLE_NONE;
    wait_idle();
    if (mismatch_count == 0) begin
      $display("huffman_tree_table_decoder: match");
    end else begin
      $display("huffman_tree_table_decoder: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("huffman_tree_table_decoder: mismatch");
    $finish;
  end

endmodule

FILE: huffman_tree_table_decoder.f
sv/htd_pkg.sv
sv/htd_front.sv
sv/htd_queue.sv
sv/htd_back.sv
sv/huffman_tree_table_decoder.sv
sim/htd_decode_checker.sv
sim/tb_huffman_tree_table_decoder.sv
